FILE: rtl/core/ffa_pkg.sv
// ffa_pkg: shared constants of the first-fit heap allocator
// used by the allocator top level and its port checker; no dependencies

package ffa_pkg;

    // request kinds carried on s_tuser
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status carried on m_tuser
    localparam logic RES_FAIL = 1'b0;
    localparam logic RES_OK   = 1'b1;

    // register defaults
    localparam logic [15:0] GROW_MIN_RESET = 16'd4096;

    // tag layout: request size 63..32, block size 31..1, used flag 0
    localparam logic [63:0] TAG_END_MARK  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] TAG_PROLOGUE  = 64'h0000_0000_0000_0011;
    localparam logic [31:0] SPLIT_MIN     = 32'd32;
    localparam logic [31:0] SETUP_BYTES   = 32'd32;
    localparam logic [31:0] WORD_BYTES    = 32'd8;
    localparam logic [31:0] TAG_PAIR      = 32'd16;

endpackage

FILE: rtl/core/first_fit_free_list_allocator.sv
// first_fit_free_list_allocator: boundary-tag heap allocator, first-fit walk
// depends on ffa_pkg and ffa_heap_ram
//
// usage: one request per transfer on the s_ side, s_tuser selects allocate
// (0) or release (1), s_tdata carries size and the body offset to release.
// every request gives exactly one result transfer on the m_ side: m_tdata is
// the body offset of the new block (0 on failure or release), m_tuser is the
// ok flag. grow_min_bytes is written through cfg_we / cfg_wdata, which the
// user must do only while idle; the block itself does not enforce it.
// all heap state sits in one word memory with registered read data; the
// sequencer does at most one memory access per cycle. an ignored release
// goes straight to the result; a release rewrites the tags, pushes the
// block on the free list and makes two coalesce checks. an allocate walks
// the free list, may grow the heap and may split the block that it takes,
// and sets up the heap first if that has not yet been done.
// one item is in work at a time; s_tready is high while the sequencer waits
// for a request, and a finished result sits in the output register so the
// next request can be taken while the receiver stalls. reset clears the
// break, the free-list head and the setup flag; heap memory contents need no
// clearing.

module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // grow_min_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // size[15:0], address[30:16], zero[31]
    input  logic        s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // address_res[14:0], zero[15]
    output logic        m_tuser        // ok
);

    localparam int HEAP_WORDS = HEAP_BYTES / 8;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int WALK_LIMIT = HEAP_BYTES / 32;
    localparam int WCW        = $clog2(WALK_LIMIT + 1);
    localparam logic [31:0] HEAP_B  = 32'(HEAP_BYTES);
    localparam logic [28:0] HEAP_W  = 29'(HEAP_WORDS);
    localparam logic [WCW-1:0] WALK_MAX = WCW'(WALK_LIMIT);

    typedef enum logic [46:0] {
        S_IDLE    = 47'b1 << 0,
        S_SETUP   = 47'b1 << 1,
        S_SU_W    = 47'b1 << 2,
        S_FF_CHK  = 47'b1 << 3,
        S_FF_TAG  = 47'b1 << 4,
        S_FF_NEXT = 47'b1 << 5,
        S_GR0     = 47'b1 << 6,
        S_GR1     = 47'b1 << 7,
        S_GR2     = 47'b1 << 8,
        S_GR3     = 47'b1 << 9,
        S_GR4     = 47'b1 << 10,
        S_GR5     = 47'b1 << 11,
        S_GR6     = 47'b1 << 12,
        S_GR7     = 47'b1 << 13,
        S_GR8     = 47'b1 << 14,
        S_TK0     = 47'b1 << 15,
        S_TK1     = 47'b1 << 16,
        S_TK_S3   = 47'b1 << 17,
        S_TK_S4   = 47'b1 << 18,
        S_TK_S5   = 47'b1 << 19,
        S_PF0     = 47'b1 << 20,
        S_PF1     = 47'b1 << 21,
        S_PF2     = 47'b1 << 22,
        S_PF3     = 47'b1 << 23,
        S_PF4     = 47'b1 << 24,
        S_PF5     = 47'b1 << 25,
        S_PF6     = 47'b1 << 26,
        S_PF7     = 47'b1 << 27,
        S_PF8     = 47'b1 << 28,
        S_PF9     = 47'b1 << 29,
        S_PF10    = 47'b1 << 30,
        S_PF11    = 47'b1 << 31,
        S_PF12    = 47'b1 << 32,
        S_JN0     = 47'b1 << 33,
        S_JN1     = 47'b1 << 34,
        S_JN2     = 47'b1 << 35,
        S_JN3     = 47'b1 << 36,
        S_JN4     = 47'b1 << 37,
        S_JN5     = 47'b1 << 38,
        S_UL0     = 47'b1 << 39,
        S_UL1     = 47'b1 << 40,
        S_UL2     = 47'b1 << 41,
        S_UL3     = 47'b1 << 42,
        S_T2_W    = 47'b1 << 43,
        S_T2_R    = 47'b1 << 44,
        S_T2_F    = 47'b1 << 45,
        S_DONE    = 47'b1 << 46
    } state_t;

    state_t state_reg, state_next;
    state_t ret_ul_reg, ret_ul_next;
    state_t ret_jn_reg, ret_jn_next;
    state_t ret_pf_reg, ret_pf_next;
    state_t ret_t2_reg, ret_t2_next;

    logic [15:0] grow_min_reg;
    logic [31:0] brk_reg, brk_next;
    logic [31:0] head_reg, head_next;
    logic        ready_reg, ready_next;

    logic [31:0] a_reg, a_next;
    logic [31:0] pb_reg, pb_next;
    logic [31:0] jx_reg, jx_next;
    logic [31:0] jn_reg, jn_next;
    logic [31:0] u_reg, u_next;
    logic [31:0] lp_reg, lp_next;
    logic [31:0] ln_reg, ln_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] sz_reg, sz_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] need_reg, need_next;
    logic [15:0] req_reg, req_next;
    logic [31:0] t2x_reg, t2x_next;
    logic [63:0] t2v_reg, t2v_next;
    logic [WCW-1:0] walk_reg, walk_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [14:0] res_addr_reg, res_addr_next;
    logic        res_ok_reg, res_ok_next;

    logic        out_valid_reg, out_valid_next;
    logic [14:0] out_addr_reg, out_addr_next;
    logic        out_ok_reg, out_ok_next;

    // memory access of this cycle
    logic        mem_we, mem_re;
    logic [31:0] mem_off;
    logic [63:0] mem_wdata;
    logic        mem_oob;
    logic        oob_d_reg;
    logic [63:0] ram_q;
    logic [63:0] rdata;
    logic [31:0] tsize;
    logic        tused;

    logic [15:0] in_size;
    logic [14:0] in_addr;
    logic [16:0] size_up;
    logic [16:0] grow_lo;
    logic [31:0] need_calc;
    logic [31:0] grow_g;
    logic        in_xfer;

    assign in_size = s_tdata[15:0];
    assign in_addr = s_tdata[30:16];
    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign mem_oob = (mem_off[31:3] >= HEAP_W);
    assign rdata   = oob_d_reg ? 64'd0 : ram_q;
    assign tsize   = {rdata[31:1], 1'b0};
    assign tused   = rdata[0];

    assign size_up   = ({1'b0, in_size} + 17'd15) & ~17'd15;
    assign need_calc = TAG_PAIR + ((in_size <= 16'd16) ? TAG_PAIR : {15'd0, size_up});
    assign grow_lo   = ({1'b0, grow_min_reg} + 17'd15) & ~17'd15;
    assign grow_g    = (need_reg < {15'd0, grow_lo}) ? {15'd0, grow_lo}
                                                    : ((need_reg + 32'd15) & ~32'd15);

    ffa_heap_ram #(
        .DEPTH (HEAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we && !mem_oob),
        .waddr (mem_off[AW+2:3]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_off[AW+2:3]),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        ret_ul_next    = ret_ul_reg;
        ret_jn_next    = ret_jn_reg;
        ret_pf_next    = ret_pf_reg;
        ret_t2_next    = ret_t2_reg;
        brk_next       = brk_reg;
        head_next      = head_reg;
        ready_next     = ready_reg;
        a_next         = a_reg;
        pb_next        = pb_reg;
        jx_next        = jx_reg;
        jn_next        = jn_reg;
        u_next         = u_reg;
        lp_next        = lp_reg;
        ln_next        = ln_reg;
        t_next         = t_reg;
        sz_next        = sz_reg;
        rem_next       = rem_reg;
        need_next      = need_reg;
        req_next       = req_reg;
        t2x_next       = t2x_reg;
        t2v_next       = t2v_reg;
        walk_next      = walk_reg;
        cnt_next       = cnt_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_off        = 32'd0;
        mem_wdata      = 64'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_addr_next = 15'd0;
                    res_ok_next   = RES_OK;
                    if (s_tuser == OP_RELEASE)
                    begin
                        if (in_addr != 15'd0 && ready_reg && {17'd0, in_addr} < brk_reg)
                        begin
                            pb_next     = {17'd0, in_addr};
                            ret_pf_next = S_DONE;
                            state_next  = S_PF0;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        req_next  = in_size;
                        need_next = need_calc;
                        a_next    = head_reg;
                        walk_next = '0;
                        state_next = ready_reg ? S_FF_CHK : S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                if (brk_reg > HEAP_B || SETUP_BYTES > HEAP_B - brk_reg)
                begin
                    res_ok_next = RES_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    a_next     = brk_reg;
                    brk_next   = brk_reg + SETUP_BYTES;
                    cnt_next   = 2'd0;
                    state_next = S_SU_W;
                end
            end
            S_SU_W:
            begin
                // end marks at both ends, a used 16-byte block between them
                mem_we    = 1'b1;
                mem_off   = a_reg + {27'd0, cnt_reg, 3'd0};
                mem_wdata = (cnt_reg == 2'd0 || cnt_reg == 2'd3) ? TAG_END_MARK
                                                                  : TAG_PROLOGUE;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    ready_next = 1'b1;
                    a_next     = head_reg;
                    state_next = S_FF_CHK;
                end
            end
            S_FF_CHK:
            begin
                if (walk_reg < WALK_MAX && a_reg != 32'd0)
                begin
                    mem_re     = 1'b1;
                    mem_off    = a_reg - WORD_BYTES;
                    state_next = S_FF_TAG;
                end
                else
                begin
                    state_next = S_GR0;
                end
            end
            S_FF_TAG:
            begin
                if (tsize >= need_reg)
                begin
                    u_next      = a_reg;
                    ret_ul_next = S_TK0;
                    state_next  = S_UL0;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_off    = a_reg + WORD_BYTES;
                    state_next = S_FF_NEXT;
                end
            end
            S_FF_NEXT:
            begin
                a_next     = rdata[31:0];
                walk_next  = walk_reg + WCW'(1);
                state_next = S_FF_CHK;
            end
            S_GR0:
            begin
                if (brk_reg > HEAP_B || grow_g > HEAP_B - brk_reg)
                begin
                    res_ok_next = RES_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    a_next      = brk_reg;
                    brk_next    = brk_reg + grow_g;
                    t2x_next    = brk_reg;
                    t2v_next    = {32'd0, grow_g};
                    ret_t2_next = S_GR1;
                    state_next  = S_T2_W;
                end
            end
            S_GR1:
            begin
                mem_re     = 1'b1;
                mem_off    = a_reg - WORD_BYTES;
                state_next = S_GR2;
            end
            S_GR2:
            begin
                // new end mark past the grown space
                mem_we     = 1'b1;
                mem_off    = a_reg + tsize - WORD_BYTES;
                mem_wdata  = TAG_END_MARK;
                state_next = S_GR3;
            end
            S_GR3:
            begin
                mem_re     = 1'b1;
                mem_off    = a_reg - TAG_PAIR;
                state_next = S_GR4;
            end
            S_GR4:
            begin
                t_next     = a_reg - tsize;
                mem_re     = 1'b1;
                mem_off    = a_reg - tsize - WORD_BYTES;
                state_next = S_GR5;
            end
            S_GR5:
            begin
                if (tused)
                begin
                    state_next = S_TK0;
                end
                else
                begin
                    sz_next    = tsize;
                    mem_re     = 1'b1;
                    mem_off    = a_reg - WORD_BYTES;
                    state_next = S_GR6;
                end
            end
            S_GR6:
            begin
                sz_next     = sz_reg + tsize;
                u_next      = t_reg;
                ret_ul_next = S_GR7;
                state_next  = S_UL0;
            end
            S_GR7:
            begin
                t2x_next    = t_reg;
                t2v_next    = {32'd0, sz_reg | 32'd1};
                ret_t2_next = S_GR8;
                state_next  = S_T2_W;
            end
            S_GR8:
            begin
                a_next     = t_reg;
                state_next = S_TK0;
            end
            S_TK0:
            begin
                res_addr_next = a_reg[14:0];
                res_ok_next   = RES_OK;
                mem_re        = 1'b1;
                mem_off       = a_reg - WORD_BYTES;
                state_next    = S_TK1;
            end
            S_TK1:
            begin
                rem_next = tsize - need_reg;
                t2x_next = a_reg;
                if (tsize - need_reg > SPLIT_MIN)
                begin
                    t2v_next    = {16'd0, req_reg, need_reg | 32'd1};
                    ret_t2_next = S_TK_S3;
                end
                else
                begin
                    t2v_next    = {16'd0, req_reg, tsize | 32'd1};
                    ret_t2_next = S_DONE;
                end
                state_next = S_T2_W;
            end
            S_TK_S3:
            begin
                mem_re     = 1'b1;
                mem_off    = a_reg - WORD_BYTES;
                state_next = S_TK_S4;
            end
            S_TK_S4:
            begin
                t2x_next    = a_reg + tsize;
                t2v_next    = {32'd0, rem_reg};
                ret_t2_next = S_TK_S5;
                state_next  = S_T2_W;
            end
            S_TK_S5:
            begin
                pb_next     = t2x_reg;
                ret_pf_next = S_DONE;
                state_next  = S_PF0;
            end
            S_PF0:
            begin
                mem_re     = 1'b1;
                mem_off    = pb_reg - WORD_BYTES;
                state_next = S_PF1;
            end
            S_PF1:
            begin
                mem_we     = 1'b1;
                mem_off    = pb_reg - WORD_BYTES;
                mem_wdata  = {32'd0, tsize};
                state_next = S_PF2;
            end
            S_PF2:
            begin
                mem_re     = 1'b1;
                mem_off    = pb_reg - WORD_BYTES;
                state_next = S_PF3;
            end
            S_PF3:
            begin
                t_next     = pb_reg + tsize - TAG_PAIR;
                mem_re     = 1'b1;
                mem_off    = pb_reg + tsize - TAG_PAIR;
                state_next = S_PF4;
            end
            S_PF4:
            begin
                mem_we     = 1'b1;
                mem_off    = t_reg;
                mem_wdata  = {32'd0, tsize};
                state_next = S_PF5;
            end
            S_PF5:
            begin
                mem_we     = 1'b1;
                mem_off    = pb_reg;
                state_next = S_PF6;
            end
            S_PF6:
            begin
                mem_we     = 1'b1;
                mem_off    = pb_reg + WORD_BYTES;
                state_next = S_PF7;
            end
            S_PF7:
            begin
                if (head_reg != 32'd0)
                begin
                    mem_we     = 1'b1;
                    mem_off    = head_reg;
                    mem_wdata  = {32'd0, pb_reg};
                    state_next = S_PF8;
                end
                else
                begin
                    state_next = S_PF9;
                end
            end
            S_PF8:
            begin
                mem_we     = 1'b1;
                mem_off    = pb_reg + WORD_BYTES;
                mem_wdata  = {32'd0, head_reg};
                state_next = S_PF9;
            end
            S_PF9:
            begin
                head_next   = pb_reg;
                jx_next     = pb_reg;
                ret_jn_next = S_PF10;
                state_next  = S_JN0;
            end
            S_PF10:
            begin
                mem_re     = 1'b1;
                mem_off    = pb_reg - TAG_PAIR;
                state_next = S_PF11;
            end
            S_PF11:
            begin
                // coalesce the block before with whatever follows it
                jx_next     = pb_reg - tsize;
                ret_jn_next = S_PF12;
                state_next  = S_JN0;
            end
            S_PF12:
            begin
                state_next = ret_pf_reg;
            end
            S_JN0:
            begin
                mem_re     = 1'b1;
                mem_off    = jx_reg - WORD_BYTES;
                state_next = S_JN1;
            end
            S_JN1:
            begin
                if (tused)
                begin
                    state_next = ret_jn_reg;
                end
                else
                begin
                    jn_next    = jx_reg + tsize;
                    mem_re     = 1'b1;
                    mem_off    = jx_reg + tsize - WORD_BYTES;
                    state_next = S_JN2;
                end
            end
            S_JN2:
            begin
                if (tused)
                begin
                    state_next = ret_jn_reg;
                end
                else
                begin
                    u_next      = jn_reg;
                    ret_ul_next = S_JN3;
                    state_next  = S_UL0;
                end
            end
            S_JN3:
            begin
                // tags are read again since the unlink reads replaced the read data
                mem_re     = 1'b1;
                mem_off    = jx_reg - WORD_BYTES;
                state_next = S_JN4;
            end
            S_JN4:
            begin
                t_next     = tsize;
                mem_re     = 1'b1;
                mem_off    = jn_reg - WORD_BYTES;
                state_next = S_JN5;
            end
            S_JN5:
            begin
                t2x_next    = jx_reg;
                t2v_next    = {32'd0, t_reg + tsize};
                ret_t2_next = ret_jn_reg;
                state_next  = S_T2_W;
            end
            S_UL0:
            begin
                mem_re     = 1'b1;
                mem_off    = u_reg;
                state_next = S_UL1;
            end
            S_UL1:
            begin
                lp_next    = rdata[31:0];
                mem_re     = 1'b1;
                mem_off    = u_reg + WORD_BYTES;
                state_next = S_UL2;
            end
            S_UL2:
            begin
                ln_next = rdata[31:0];
                if (lp_reg != 32'd0)
                begin
                    mem_we    = 1'b1;
                    mem_off   = lp_reg + WORD_BYTES;
                    mem_wdata = {32'd0, rdata[31:0]};
                end
                state_next = S_UL3;
            end
            S_UL3:
            begin
                if (ln_reg != 32'd0)
                begin
                    mem_we    = 1'b1;
                    mem_off   = ln_reg;
                    mem_wdata = {32'd0, lp_reg};
                end
                if (u_reg == head_reg)
                begin
                    head_next = ln_reg;
                end
                state_next = ret_ul_reg;
            end
            S_T2_W:
            begin
                mem_we     = 1'b1;
                mem_off    = t2x_reg - WORD_BYTES;
                mem_wdata  = t2v_reg;
                state_next = S_T2_R;
            end
            S_T2_R:
            begin
                mem_re     = 1'b1;
                mem_off    = t2x_reg - WORD_BYTES;
                state_next = S_T2_F;
            end
            S_T2_F:
            begin
                // footer sits where the freshly written header says
                mem_we     = 1'b1;
                mem_off    = t2x_reg + tsize - TAG_PAIR;
                mem_wdata  = t2v_reg;
                state_next = ret_t2_reg;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_ul_reg    <= S_IDLE;
            ret_jn_reg    <= S_IDLE;
            ret_pf_reg    <= S_IDLE;
            ret_t2_reg    <= S_IDLE;
            grow_min_reg  <= GROW_MIN_RESET;
            brk_reg       <= 32'd0;
            head_reg      <= 32'd0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            oob_d_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_ul_reg    <= ret_ul_next;
            ret_jn_reg    <= ret_jn_next;
            ret_pf_reg    <= ret_pf_next;
            ret_t2_reg    <= ret_t2_next;
            if (cfg_we)
            begin
                grow_min_reg <= cfg_wdata;
            end
            brk_reg       <= brk_next;
            head_reg      <= head_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (mem_re)
            begin
                oob_d_reg <= mem_oob;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        pb_reg       <= pb_next;
        jx_reg       <= jx_next;
        jn_reg       <= jn_next;
        u_reg        <= u_next;
        lp_reg       <= lp_next;
        ln_reg       <= ln_next;
        t_reg        <= t_next;
        sz_reg       <= sz_next;
        rem_reg      <= rem_next;
        need_reg     <= need_next;
        req_reg      <= req_next;
        t2x_reg      <= t2x_next;
        t2v_reg      <= t2v_next;
        walk_reg     <= walk_next;
        cnt_reg      <= cnt_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        out_addr_reg <= out_addr_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_addr_reg};
    assign m_tuser  = out_ok_reg;

endmodule

FILE: rtl/core/ffa_heap_ram.sv
// ffa_heap_ram: single-clock heap word memory, one write and one read port
// read data registered; no dependencies

module ffa_heap_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/ffa_checker.sv
// ffa_checker: port-level assertions for the first-fit heap allocator
// depends on ffa_pkg; bound to first_fit_free_list_allocator below

module ffa_checker
    import ffa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // a failed allocate reports no address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == RES_FAIL |-> m_tdata == 16'd0)
        else $error("failed allocate carries an address");

    // a new result only after a request was taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready || $past(!s_tready))
        else $error("result without a request");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_first_fit_free_list_allocator.sv
// tb_first_fit_free_list_allocator: self-checking bench for the first-fit heap allocator
// keeps its own boundary-tag heap in step with the requests it sends; needs ffa_pkg and the rtl
`timescale 1ns / 1ps

module tb_first_fit_free_list_allocator;
    import ffa_pkg::*;

    localparam int unsigned HEAP_SZ   = 32768;
    localparam int unsigned HEAP_WDS  = HEAP_SZ / 8;
    localparam int unsigned WALK_MAX  = HEAP_SZ / 32;
    localparam int unsigned SZ_MASK   = 32'hffff_fffe;
    localparam int          RAND_ITEMS = 1200;

    typedef struct packed {
        logic        op;
        logic [15:0] size;
        logic [14:0] addr;
    } req_t;

    typedef struct packed {
        logic [14:0] addr;
        logic        ok;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    first_fit_free_list_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow heap
    logic [63:0] heap_mem [0:HEAP_WDS-1];
    int unsigned brk;
    int unsigned free_head;
    bit          heap_ready;
    int unsigned grow_min;

    req_t        pending_reqs [$];
    res_t        expected_res [$];
    int unsigned live_blocks [$];
    int          errors;
    bit          no_idle;

    function automatic logic [63:0] rd(int unsigned off);
        int unsigned i;
        i = off >> 3;
        return (i < HEAP_WDS) ? heap_mem[i] : 64'd0;
    endfunction

    function automatic void wr(int unsigned off, logic [63:0] v);
        int unsigned i;
        i = off >> 3;
        if (i < HEAP_WDS)
            heap_mem[i] = v;
    endfunction

    function automatic int unsigned tag_sz(int unsigned t);
        logic [63:0] w;
        w = rd(t);
        return w[31:0] & SZ_MASK;
    endfunction

    function automatic bit tag_used(int unsigned t);
        logic [63:0] w;
        w = rd(t);
        return w[0];
    endfunction

    function automatic void set_tag(int unsigned t, int unsigned rs, int unsigned bs, bit u);
        wr(t, {rs, bs | {31'd0, u}});
    endfunction

    function automatic int unsigned foot_of(int unsigned b);
        return b + tag_sz(b - 8) - 16;
    endfunction

    function automatic int unsigned after_of(int unsigned b);
        return b + tag_sz(b - 8);
    endfunction

    function automatic int unsigned before_of(int unsigned b);
        return b - tag_sz(b - 16);
    endfunction

    function automatic void unlink_blk(int unsigned b);
        logic [63:0] wp, wn;
        int unsigned p, n;
        wp = rd(b);
        wn = rd(b + 8);
        p = wp[31:0];
        n = wn[31:0];
        if (p != 0)
            wr(p + 8, {32'd0, n});
        if (n != 0)
            wr(n, {32'd0, p});
        if (b == free_head)
            free_head = n;
    endfunction

    function automatic void merge_next(int unsigned b);
        int unsigned n, sz;
        if (tag_used(b - 8))
            return;
        n = after_of(b);
        if (tag_used(n - 8))
            return;
        unlink_blk(n);
        sz = tag_sz(b - 8) + tag_sz(n - 8);
        set_tag(b - 8, 0, sz, 1'b0);
        set_tag(foot_of(b), 0, sz, 1'b0);
    endfunction

    function automatic void push_free(int unsigned b);
        int unsigned f;
        wr(b - 8, rd(b - 8) & {32'd0, SZ_MASK});
        f = foot_of(b);
        wr(f, rd(f) & {32'd0, SZ_MASK});
        wr(b, 64'd0);
        wr(b + 8, 64'd0);
        if (free_head != 0)
        begin
            wr(free_head, {32'd0, b});
            wr(b + 8, {32'd0, free_head});
        end
        free_head = b;
        merge_next(b);
        merge_next(before_of(b));
    endfunction

    function automatic int unsigned first_fit(int unsigned need);
        int unsigned b, k;
        logic [63:0] w;
        b = free_head;
        for (k = 0; k < WALK_MAX && b != 0; k++)
        begin
            if (tag_sz(b - 8) >= need)
            begin
                unlink_blk(b);
                return b;
            end
            w = rd(b + 8);
            b = w[31:0];
        end
        return 0;
    endfunction

    function automatic int unsigned grow_heap(int unsigned need);
        int unsigned g, lo, b, q, sz;
        g = need;
        lo = (grow_min + 15) & ~32'd15;
        if (g < lo)
            g = lo;
        else
            g = (g + 15) & ~32'd15;
        if (brk > HEAP_SZ || g > HEAP_SZ - brk)
            return 0;
        b = brk;
        brk += g;
        set_tag(b - 8, 0, g, 1'b0);
        set_tag(foot_of(b), 0, g, 1'b0);
        set_tag(after_of(b) - 8, 0, 0, 1'b1);
        q = before_of(b);
        if (!tag_used(q - 8))
        begin
            sz = tag_sz(q - 8) + tag_sz(b - 8);
            unlink_blk(q);
            set_tag(q - 8, 0, sz, 1'b1);
            set_tag(foot_of(q), 0, sz, 1'b1);
            return q;
        end
        return b;
    endfunction

    function automatic void take_block(int unsigned b, int unsigned need, int unsigned req);
        int unsigned sz, rem, r;
        sz = tag_sz(b - 8);
        rem = sz - need;
        if (rem > SPLIT_MIN)
        begin
            set_tag(b - 8, req, need, 1'b1);
            set_tag(foot_of(b), req, need, 1'b1);
            r = after_of(b);
            set_tag(r - 8, 0, rem, 1'b0);
            set_tag(foot_of(r), 0, rem, 1'b0);
            push_free(r);
        end
        else
        begin
            set_tag(b - 8, req, sz, 1'b1);
            set_tag(foot_of(b), req, sz, 1'b1);
        end
    endfunction

    // computes the response of one request and updates the shadow heap
    function automatic res_t heap_request(req_t rq);
        res_t        r;
        int unsigned need, b, p;
        r.addr = '0;
        r.ok = RES_OK;
        if (rq.op == OP_RELEASE)
        begin
            if (rq.addr != 0 && heap_ready && rq.addr < brk)
                push_free({17'd0, rq.addr});
            return r;
        end
        if (!heap_ready)
        begin
            p = brk;
            if (p > HEAP_SZ || SETUP_BYTES > HEAP_SZ - p)
            begin
                r.ok = RES_FAIL;
                return r;
            end
            brk = p + SETUP_BYTES;
            set_tag(p, 0, 0, 1'b1);
            set_tag(p + 8, 0, 16, 1'b1);
            set_tag(p + 16, 0, 16, 1'b1);
            set_tag(p + 24, 0, 0, 1'b1);
            heap_ready = 1'b1;
        end
        need = 16 + ((rq.size <= 16) ? 16 : ((rq.size + 15) & ~32'd15));
        b = first_fit(need);
        if (b == 0)
        begin
            b = grow_heap(need);
            if (b == 0)
            begin
                r.ok = RES_FAIL;
                return r;
            end
        end
        take_block(b, need, {16'd0, rq.size});
        r.addr = b[14:0];
        return r;
    endfunction

    task automatic send(logic op, logic [15:0] size, logic [14:0] addr);
        req_t rq;
        res_t rs;
        rq.op = op;
        rq.size = size;
        rq.addr = addr;
        rs = heap_request(rq);
        if (op == OP_ALLOC && rs.ok == RES_OK)
            live_blocks.push_back({17'd0, rs.addr});
        pending_reqs.push_back(rq);
        expected_res.push_back(rs);
    endtask

    task automatic release_live(int idx);
        int unsigned a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        send(OP_RELEASE, 16'($urandom), a[14:0]);
    endtask

    task automatic random_item();
        int unsigned k, a;
        k = $urandom_range(0, 99);
        if (k < 52 || (k < 90 && live_blocks.size() == 0))
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
                send(OP_ALLOC, 16'($urandom_range(0, 256)), 15'($urandom));
            else if (k < 93)
                send(OP_ALLOC, 16'($urandom_range(257, 3000)), 15'($urandom));
            else
                send(OP_ALLOC, 16'($urandom_range(3001, 32768)), 15'($urandom));
        end
        else if (k < 90)
        begin
            release_live($urandom_range(0, live_blocks.size() - 1));
        end
        else
        begin
            // releases that must be ignored: null or at/after the break
            a = (brk < HEAP_SZ && $urandom_range(0, 2) != 0) ?
                $urandom_range(brk, HEAP_SZ - 1) : 0;
            send(OP_RELEASE, 16'($urandom), a[14:0]);
        end
    endtask

    function automatic int idle_len();
        int unsigned k;
        if (no_idle)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drain_and_config(logic [15:0] v);
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        repeat (60) @(posedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        grow_min = {16'd0, v};
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                void'(pending_reqs.pop_front());
            if (s_tvalid && !s_tready)
            begin
                // hold the current transfer
            end
            else if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, pending_reqs[0].addr, pending_reqs[0].size};
                s_tuser <= pending_reqs[0].op;
                src_gap = idle_len();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    int   sink_gap;
    res_t exp_r;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result addr=%0d ok=%0b", $time,
                             m_tdata[14:0], m_tuser);
                    errors++;
                end
                else
                begin
                    exp_r = expected_res.pop_front();
                    if (m_tdata[14:0] !== exp_r.addr || m_tdata[15] !== 1'b0)
                    begin
                        $display("%0t: address mismatch expected %0d actual %0d", $time,
                                 exp_r.addr, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== exp_r.ok)
                    begin
                        $display("%0t: ok mismatch expected %0b actual %0b", $time,
                                 exp_r.ok, m_tuser);
                        errors++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_gap = idle_len();
            end
        end
    end

    initial
    begin
        #300ms;
        $display("FAIL");
        $finish;
    end

    logic [15:0] grow_settings [$];
    initial
    begin
        errors = 0;
        no_idle = 0;
        brk = 0;
        free_head = 0;
        heap_ready = 0;
        grow_min = {16'd0, GROW_MIN_RESET};
        foreach (heap_mem[i])
            heap_mem[i] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: releases before setup, size edges, coalescing, exhaustion
        send(OP_RELEASE, 16'h0, 15'd24);
        send(OP_RELEASE, 16'hffff, 15'h7fff);
        send(OP_ALLOC, 16'd0, 15'h7fff);
        send(OP_ALLOC, 16'd16, 15'd0);
        send(OP_ALLOC, 16'd17, 15'd0);
        send(OP_ALLOC, 16'd100, 15'd0);
        send(OP_ALLOC, 16'd32767, 15'd0);
        send(OP_ALLOC, 16'd32768, 15'd0);
        send(OP_RELEASE, 16'd0, 15'd0);
        send(OP_RELEASE, 16'd0, 15'h7fff);
        release_live(1);
        release_live(1);
        release_live(0);
        send(OP_ALLOC, 16'd5000, 15'd0);
        send(OP_ALLOC, 16'd48, 15'd0);
        send(OP_ALLOC, 16'd64, 15'd0);
        send(OP_ALLOC, 16'd80, 15'd0);
        release_live(2);
        release_live(1);
        send(OP_ALLOC, 16'd20000, 15'd0);
        send(OP_ALLOC, 16'd16000, 15'd0);
        send(OP_ALLOC, 16'd1, 15'd0);

        grow_settings = '{16'd32, 16'd32768, 16'd0, 16'hffff, 16'd4096, 16'd512};
        repeat (3)
            grow_settings.push_back(16'($urandom_range(2, 200) * 16));
        foreach (grow_settings[p])
        begin
            drain_and_config(grow_settings[p]);
            no_idle = (p % 3 == 2);
            // free everything now and then so the heap does not stay full
            if (p % 2 == 1)
                while (live_blocks.size() > 0)
                    release_live($urandom_range(0, live_blocks.size() - 1));
            repeat (RAND_ITEMS / grow_settings.size())
                random_item();
        end

        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_heap_ram.sv
rtl/core/first_fit_free_list_allocator.sv
rtl/core/ffa_checker.sv
tb/tb_first_fit_free_list_allocator.sv
